>>> hw/rtl/kfip_pkg.sv
// ----------------------------------------------------------------------------
// kfip_pkg
// Shared types, codes and message tables of the k-line fast-init poller.
// ----------------------------------------------------------------------------
package kfip_pkg;

    localparam int RxDepthDef     = 16;
    localparam int SensorCountDef = 4;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START      = 4'd1,
        PH_WAKE_HIGH  = 4'd2,
        PH_WAKE_LOW   = 4'd3,
        PH_WAKE_END   = 4'd4,
        PH_SEND_START = 4'd5,
        PH_AWAIT_START = 4'd6,
        PH_GAP        = 4'd7,
        PH_SEND_POLL  = 4'd8,
        PH_AWAIT_POLL = 4'd9,
        PH_SEND_STOP  = 4'd10,
        PH_AWAIT_STOP = 4'd11
    } t_phase;

    // result kinds
    localparam logic [2:0] WHAT_EVENT = 3'd0;
    localparam logic [2:0] WHAT_VALUE = 3'd1;
    localparam logic [2:0] WHAT_TX    = 3'd2;
    localparam logic [2:0] WHAT_LINE  = 3'd3;
    localparam logic [2:0] WHAT_DONE  = 3'd4;

    // status events
    localparam logic [3:0] EV_INIT_OK        = 4'd0;
    localparam logic [3:0] EV_STOP_OK        = 4'd1;
    localparam logic [3:0] EV_BAD_SENSOR     = 4'd2;
    localparam logic [3:0] EV_ALREADY_STOPPED = 4'd3;
    localparam logic [3:0] EV_INIT_BUSY      = 4'd4;
    localparam logic [3:0] EV_INIT_FAILED    = 4'd5;
    localparam logic [3:0] EV_ALREADY_INIT   = 4'd6;
    localparam logic [3:0] EV_INIT_STOPPING  = 4'd7;
    localparam logic [3:0] EV_STOP_BUSY      = 4'd8;
    localparam logic [3:0] EV_STOP_FAILED    = 4'd9;

    // line levels
    localparam logic [1:0] LINE_UART = 2'd0;
    localparam logic [1:0] LINE_HIGH = 2'd1;
    localparam logic [1:0] LINE_LOW  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_WAKE_IDLE = 3'd0;
    localparam logic [2:0] REG_WAKE_LOW  = 3'd1;
    localparam logic [2:0] REG_WAKE_HIGH = 3'd2;
    localparam logic [2:0] REG_BYTE_GAP  = 3'd3;
    localparam logic [2:0] REG_REPLY_TO  = 3'd4;
    localparam logic [2:0] REG_POLL_TO   = 3'd5;
    localparam logic [2:0] REG_ONE_SHOT  = 3'd6;

    localparam logic [7:0] START_ACK = 8'hC1;
    localparam logic [7:0] STOP_ACK  = 8'hC2;
    localparam logic [7:0] TEMP_OFS  = 8'd40;

    typedef struct packed {
        logic [2:0]        what;
        logic [3:0]        event_code;
        logic [7:0]        tx_byte;
        logic [1:0]        line_level;
        logic [1:0]        value_sensor;
        logic signed [14:0] sensor_value;
        logic              accepted;
        logic              last;
    } t_result;

    typedef struct packed {
        logic       kind;
        logic       init_req;
        logic       stop_req;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [2:0] sensor;
    } t_item;

    function automatic logic [7:0] start_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'hC1;
            3'd1: b = 8'h33;
            3'd2: b = 8'hF1;
            3'd3: b = 8'h81;
            3'd4: b = 8'h66;
            default: b = 8'hC1;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] stop_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'hC1;
            3'd1: b = 8'h33;
            3'd2: b = 8'hF1;
            3'd3: b = 8'h82;
            3'd4: b = 8'h67;
            default: b = 8'hC1;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] poll_byte(input logic [1:0] s, input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'hC2;
            3'd1: b = 8'h33;
            3'd2: b = 8'hF1;
            3'd3: b = 8'h01;
            3'd4: begin
                case (s)
                    2'd0: b = 8'h0C;
                    2'd1: b = 8'h05;
                    2'd2: b = 8'h0F;
                    default: b = 8'h0D;
                endcase
            end
            3'd5: begin
                case (s)
                    2'd0: b = 8'hF3;
                    2'd1: b = 8'hEC;
                    2'd2: b = 8'hF6;
                    default: b = 8'hF4;
                endcase
            end
            default: b = 8'hC2;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/kfip_if.sv
// ----------------------------------------------------------------------------
// kfip channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface kfip_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic       init_req;
    logic       stop_req;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [2:0] sensor;
    modport source (output valid, kind, init_req, stop_req, rx_valid, rx_data, sensor,
                    input ready);
    modport sink (input valid, kind, init_req, stop_req, rx_valid, rx_data, sensor,
                  output ready);
endinterface

interface kfip_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        what;
    logic [3:0]        event_code;
    logic [7:0]        tx_byte;
    logic [1:0]        line_level;
    logic [1:0]        value_sensor;
    logic signed [14:0] sensor_value;
    logic              accepted;
    logic              last;
    modport source (output valid, what, event_code, tx_byte, line_level, value_sensor,
                    sensor_value, accepted, last, input ready);
    modport sink (input valid, what, event_code, tx_byte, line_level, value_sensor,
                  sensor_value, accepted, last, output ready);
endinterface

interface kfip_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/kfip_out_queue.sv
// ----------------------------------------------------------------------------
// kfip_out_queue
// Holds up to four results of one request, draining one per cycle while ready.
// ----------------------------------------------------------------------------
module kfip_out_queue
    import kfip_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result [3:0] i_res,
    input  logic [2:0]    i_cnt,
    output logic          o_empty,
    output logic          o_valid,
    output t_result       o_res,
    input  logic          i_ready
);
    t_result [3:0] r_res;
    logic [2:0]    r_cnt;
    logic [1:0]    r_pos;

    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_res[r_pos];
    assign o_empty = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_ready);

    // load a new group or pop one result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_pos <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_pos <= 2'd0;
        end else if (o_valid && i_ready) begin
            r_cnt <= r_cnt - 3'd1;
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_res <= i_res;
    end

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_empty) else $error("queue loaded while results pending");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cnt == 3'd1) |-> o_res.last) else $error("final result lacks last");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count out of range");
endmodule

>>> hw/rtl/kline_fast_init_poller_top.sv
// ----------------------------------------------------------------------------
// kline_fast_init_poller_top
// K-line fast-init controller with round-robin sensor polling.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one request per millisecond step or subscribe; out_ch
// returns one to four results per request, the final one flagged last (step
// done); cfg_ch writes the timing registers and one-shot mask, which the user
// must write only while idle; the block does not enforce it. A request is
// decoded in the cycle it is accepted, its results are loaded into a
// four-entry result queue at that edge and appear from the next cycle, one per
// cycle while out_ch is ready. A new request is taken when the queue holds at
// most one result, taken in that cycle; the single output port paces requests.
// Reset (synchronous, active low) returns to idle with no subscriptions and
// the register reset values. When the receiver stalls, results stay in the
// queue and in_ch.ready drops until the queue drains. The received-byte
// store is undefined until written.
// ----------------------------------------------------------------------------
module kline_fast_init_poller_top
    import kfip_pkg::*;
#(
    parameter int RX_DEPTH     = RxDepthDef,
    parameter int SENSOR_COUNT = SensorCountDef
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    kfip_in_if.sink    in_ch,
    kfip_out_if.source out_ch,
    kfip_cfg_if.sink   cfg_ch
);
    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam int AW = $clog2(RX_DEPTH);

    // registers
    logic [9:0] r_wake_idle;
    logic [7:0] r_wake_low, r_wake_high, r_byte_gap, r_reply_to, r_poll_to;
    logic [SENSOR_COUNT-1:0] r_one_shot;

    // state
    t_phase     r_phase, n_phase;
    logic [15:0] r_elapsed, n_elapsed;
    logic [2:0] r_tx_idx, n_tx_idx;
    logic [7:0] r_rx [RX_DEPTH];
    logic [CW-1:0] r_rx_cnt, n_rx_cnt;
    logic       r_stop_pend, n_stop_pend;
    logic [1:0] r_sub [SENSOR_COUNT];
    logic [1:0] n_sub [SENSOR_COUNT];
    logic [2:0] r_sub_cnt, n_sub_cnt;
    logic [1:0] r_sub_pos, n_sub_pos;
    logic [1:0] r_cur, n_cur;

    logic          q_empty, q_valid;
    t_result       q_res;
    t_result [3:0] res;
    logic [2:0]    res_n;
    logic          acc;
    t_item         it;
    logic          wr_en;
    logic [7:0]    rx8, rx11, rx12;

    assign in_ch.ready  = q_empty;
    assign cfg_ch.ready = 1'b1;
    assign acc = in_ch.valid && in_ch.ready;
    assign it  = '{kind: in_ch.kind, init_req: in_ch.init_req, stop_req: in_ch.stop_req,
                   rx_valid: in_ch.rx_valid, rx_data: in_ch.rx_data, sensor: in_ch.sensor};
    assign rx8  = r_rx[8];
    assign rx11 = r_rx[11];
    assign rx12 = r_rx[12];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_idle <= 10'd300;
            r_wake_low  <= 8'd25;
            r_wake_high <= 8'd25;
            r_byte_gap  <= 8'd10;
            r_reply_to  <= 8'd100;
            r_poll_to   <= 8'd60;
            r_one_shot  <= '0;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_WAKE_IDLE: r_wake_idle <= cfg_ch.data;
                REG_WAKE_LOW:  r_wake_low  <= cfg_ch.data[7:0];
                REG_WAKE_HIGH: r_wake_high <= cfg_ch.data[7:0];
                REG_BYTE_GAP:  r_byte_gap  <= cfg_ch.data[7:0];
                REG_REPLY_TO:  r_reply_to  <= cfg_ch.data[7:0];
                REG_POLL_TO:   r_poll_to   <= cfg_ch.data[7:0];
                REG_ONE_SHOT:  r_one_shot  <= cfg_ch.data[SENSOR_COUNT-1:0];
                default: ;
            endcase
        end
    end

    // controller step: next state and results
    always_comb begin
        logic [15:0] el;
        logic [CW-1:0] cnt1;
        logic found;
        logic [7:0] b8;
        logic [7:0] b11;
        logic [7:0] b12;
        logic [4:0] rlen;
        logic [2:0] sc;
        logic [2:0] pos1;
        logic [15:0] rpm;
        t_result r;

        n_phase = r_phase; n_elapsed = r_elapsed; n_tx_idx = r_tx_idx;
        n_rx_cnt = r_rx_cnt; n_stop_pend = r_stop_pend;
        n_sub = r_sub; n_sub_cnt = r_sub_cnt; n_sub_pos = r_sub_pos; n_cur = r_cur;
        wr_en = 1'b0;
        res = '0; res_n = 3'd0; r = '0;
        found = 1'b0; sc = r_sub_cnt; pos1 = 3'd0; rpm = '0;
        el = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
        cnt1 = r_rx_cnt;
        // byte just stored may be one of the checked positions
        b8 = rx8; b11 = rx11; b12 = rx12;
        if (r_rx_cnt == CW'(8))  b8  = it.rx_data;
        if (r_rx_cnt == CW'(11)) b11 = it.rx_data;
        if (r_rx_cnt == CW'(12)) b12 = it.rx_data;
        rlen = (r_cur == 2'd0) ? 5'd14 : 5'd13;

        if (it.kind) begin
            if (it.sensor[2]) begin
                res[res_n[1:0]] = '0; res[res_n[1:0]].event_code = EV_BAD_SENSOR;
                res_n = res_n + 3'd1;
            end else begin
                for (int i = 0; i < SENSOR_COUNT; i++)
                    if (3'(i) < r_sub_cnt && r_sub[i] == it.sensor[1:0]) found = 1'b1;
                if (!found && r_sub_cnt < 3'(SENSOR_COUNT)) begin
                    n_sub[r_sub_cnt[1:0]] = it.sensor[1:0];
                    n_sub_cnt = r_sub_cnt + 3'd1;
                end
            end
            r = '0; r.what = WHAT_DONE; r.accepted = !it.sensor[2]; r.last = 1'b1;
            res[res_n[1:0]] = r; res_n = res_n + 3'd1;
        end else begin
            n_elapsed = el;
            case (r_phase)
                PH_START, PH_WAKE_HIGH, PH_WAKE_LOW, PH_WAKE_END, PH_SEND_START: begin
                    if (it.init_req) begin
                        r = '0; r.event_code = EV_INIT_BUSY; res[res_n[1:0]] = r;
                        res_n = res_n + 3'd1;
                    end
                    r = '0;
                    if (it.stop_req) begin
                        n_phase = PH_IDLE;
                        r.event_code = EV_STOP_OK; res[res_n[1:0]] = r;
                        res_n = res_n + 3'd1;
                    end else if (r_phase == PH_START) begin
                        n_elapsed = '0; n_phase = PH_WAKE_HIGH;
                        r.what = WHAT_LINE; r.line_level = LINE_HIGH;
                        res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                    end else if (r_phase == PH_WAKE_HIGH) begin
                        if (el >= {6'd0, r_wake_idle}) begin
                            n_elapsed = '0; n_phase = PH_WAKE_LOW;
                            r.what = WHAT_LINE; r.line_level = LINE_LOW;
                            res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                        end
                    end else if (r_phase == PH_WAKE_LOW) begin
                        if (el >= {8'd0, r_wake_low}) begin
                            n_elapsed = '0; n_phase = PH_WAKE_END;
                            r.what = WHAT_LINE; r.line_level = LINE_HIGH;
                            res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                        end
                    end else if (r_phase == PH_WAKE_END) begin
                        if (el >= {8'd0, r_wake_high}) begin
                            n_rx_cnt = '0; n_tx_idx = '0; n_phase = PH_SEND_START;
                            r.what = WHAT_LINE; r.line_level = LINE_UART;
                            res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                        end
                    end else begin
                        if (it.rx_valid && r_rx_cnt < CW'(RX_DEPTH)) begin
                            wr_en = 1'b1; n_rx_cnt = r_rx_cnt + CW'(1);
                        end
                        if (el >= {8'd0, r_byte_gap}) begin
                            r.what = WHAT_TX; r.tx_byte = start_byte(r_tx_idx);
                            res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                            n_elapsed = '0;
                            if (r_tx_idx >= 3'd4) begin
                                n_tx_idx = '0; n_phase = PH_AWAIT_START;
                            end else n_tx_idx = r_tx_idx + 3'd1;
                        end
                    end
                end
                PH_AWAIT_START: begin
                    if (it.init_req) begin
                        r = '0; r.event_code = EV_INIT_BUSY; res[res_n[1:0]] = r;
                        res_n = res_n + 3'd1;
                    end
                    if (it.stop_req) n_stop_pend = 1'b1;
                    r = '0;
                    if (el > {8'd0, r_reply_to}) begin
                        n_phase = PH_IDLE;
                        r.event_code = EV_INIT_FAILED; res[res_n[1:0]] = r;
                        res_n = res_n + 3'd1;
                        if (n_stop_pend) begin
                            n_stop_pend = 1'b0;
                            r.event_code = EV_STOP_OK; res[res_n[1:0]] = r;
                            res_n = res_n + 3'd1;
                        end
                    end else if (it.rx_valid) begin
                        if (r_rx_cnt < CW'(RX_DEPTH)) begin
                            wr_en = 1'b1; cnt1 = r_rx_cnt + CW'(1);
                        end
                        n_rx_cnt = cnt1;
                        if (cnt1 >= CW'(12)) begin
                            n_elapsed = '0;
                            if (b8 == START_ACK) begin
                                n_phase = PH_GAP;
                                if (!n_stop_pend) begin
                                    r.event_code = EV_INIT_OK; res[res_n[1:0]] = r;
                                    res_n = res_n + 3'd1;
                                    n_sub_pos = '0;
                                    n_cur = (r_sub_cnt != 3'd0) ? r_sub[0] : 2'd0;
                                end
                            end else begin
                                n_stop_pend = 1'b0; n_phase = PH_IDLE;
                                r.event_code = EV_INIT_FAILED; res[res_n[1:0]] = r;
                                res_n = res_n + 3'd1;
                            end
                        end
                    end
                end
                PH_GAP, PH_SEND_POLL, PH_AWAIT_POLL: begin
                    if (it.init_req) begin
                        r = '0; r.event_code = EV_ALREADY_INIT; res[res_n[1:0]] = r;
                        res_n = res_n + 3'd1;
                    end
                    if (it.stop_req) n_stop_pend = 1'b1;
                    r = '0;
                    if (r_phase == PH_GAP) begin
                        if (el > {8'd0, r_reply_to}) begin
                            n_rx_cnt = '0; n_tx_idx = '0;
                            n_phase = n_stop_pend ? PH_SEND_STOP : PH_SEND_POLL;
                        end
                    end else if (r_phase == PH_SEND_POLL) begin
                        if (it.rx_valid && r_rx_cnt < CW'(RX_DEPTH)) begin
                            wr_en = 1'b1; n_rx_cnt = r_rx_cnt + CW'(1);
                        end
                        if (el >= {8'd0, r_byte_gap}) begin
                            r.what = WHAT_TX; r.tx_byte = poll_byte(r_cur, r_tx_idx);
                            res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                            n_elapsed = '0;
                            if (r_tx_idx >= 3'd5) begin
                                n_tx_idx = '0; n_phase = PH_AWAIT_POLL;
                            end else n_tx_idx = r_tx_idx + 3'd1;
                        end
                    end else begin
                        if (el > {8'd0, r_poll_to}) begin
                            n_tx_idx = '0; n_rx_cnt = '0;
                            n_phase = n_stop_pend ? PH_SEND_STOP : PH_SEND_POLL;
                        end else if (it.rx_valid) begin
                            if (r_rx_cnt < CW'(RX_DEPTH)) begin
                                wr_en = 1'b1; cnt1 = r_rx_cnt + CW'(1);
                            end
                            n_rx_cnt = cnt1;
                            n_elapsed = '0;
                            if (cnt1 >= CW'(rlen)) begin
                                if (!n_stop_pend) begin
                                    if (r_sub_cnt != 3'd0) begin
                                        r.what = WHAT_VALUE; r.value_sensor = r_cur;
                                        rpm = {b11, b12};
                                        if (r_cur == 2'd0)
                                            r.sensor_value = {1'b0, rpm[15:2]};
                                        else if (r_cur == 2'd3)
                                            r.sensor_value = {7'd0, b11};
                                        else
                                            r.sensor_value = 15'({7'd0, b11}) - 15'(TEMP_OFS);
                                        res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                                        if (r_one_shot[r_cur]) begin
                                            for (int i = 1; i < SENSOR_COUNT; i++)
                                                if (3'(i) > {1'b0, r_sub_pos} &&
                                                    3'(i) < r_sub_cnt)
                                                    n_sub[i-1] = r_sub[i];
                                            sc = r_sub_cnt - 3'd1;
                                        end
                                    end
                                    n_sub_cnt = sc;
                                    if (sc != 3'd0) begin
                                        pos1 = {1'b0, r_sub_pos} + 3'd1;
                                        if (pos1 >= sc) pos1 = 3'd0;
                                        n_sub_pos = pos1[1:0];
                                        n_cur = n_sub[pos1[1:0]];
                                    end else n_cur = 2'd0;
                                end
                                n_phase = PH_GAP;
                            end
                        end
                    end
                end
                PH_SEND_STOP, PH_AWAIT_STOP: begin
                    if (it.init_req) begin
                        r = '0; r.event_code = EV_INIT_STOPPING; res[res_n[1:0]] = r;
                        res_n = res_n + 3'd1;
                    end
                    if (it.stop_req) begin
                        r = '0; r.event_code = EV_STOP_BUSY; res[res_n[1:0]] = r;
                        res_n = res_n + 3'd1;
                    end
                    r = '0;
                    if (r_phase == PH_SEND_STOP) begin
                        if (it.rx_valid && r_rx_cnt < CW'(RX_DEPTH)) begin
                            wr_en = 1'b1; n_rx_cnt = r_rx_cnt + CW'(1);
                        end
                        if (el >= {8'd0, r_byte_gap}) begin
                            r.what = WHAT_TX; r.tx_byte = stop_byte(r_tx_idx);
                            res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                            n_elapsed = '0;
                            if (r_tx_idx >= 3'd4) begin
                                n_tx_idx = '0; n_phase = PH_AWAIT_STOP;
                            end else n_tx_idx = r_tx_idx + 3'd1;
                        end
                    end else begin
                        if (el > {8'd0, r_reply_to}) begin
                            n_stop_pend = 1'b0; n_phase = PH_IDLE;
                            r.event_code = EV_STOP_FAILED; res[res_n[1:0]] = r;
                            res_n = res_n + 3'd1;
                        end else if (it.rx_valid) begin
                            if (r_rx_cnt < CW'(RX_DEPTH)) begin
                                wr_en = 1'b1; cnt1 = r_rx_cnt + CW'(1);
                            end
                            n_rx_cnt = cnt1;
                            if (cnt1 >= CW'(12)) begin
                                n_elapsed = '0; n_stop_pend = 1'b0; n_phase = PH_IDLE;
                                r.event_code = (b8 == STOP_ACK) ? EV_STOP_OK : EV_STOP_FAILED;
                                res[res_n[1:0]] = r; res_n = res_n + 3'd1;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (it.stop_req) begin
                        r = '0; r.event_code = EV_ALREADY_STOPPED; res[res_n[1:0]] = r;
                        res_n = res_n + 3'd1;
                    end
                    if (it.init_req) n_phase = PH_START;
                end
            endcase
            r = '0; r.what = WHAT_DONE; r.last = 1'b1;
            res[res_n[1:0]] = r; res_n = res_n + 3'd1;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_elapsed <= '0; r_tx_idx <= '0; r_rx_cnt <= '0;
            r_stop_pend <= 1'b0; r_sub_cnt <= '0; r_sub_pos <= '0; r_cur <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++) r_sub[i] <= '0;
        end else if (acc) begin
            r_phase <= n_phase; r_elapsed <= n_elapsed; r_tx_idx <= n_tx_idx;
            r_rx_cnt <= n_rx_cnt; r_stop_pend <= n_stop_pend; r_sub_cnt <= n_sub_cnt;
            r_sub_pos <= n_sub_pos; r_cur <= n_cur; r_sub <= n_sub;
        end
    end

    // received byte store
    always_ff @(posedge i_clk) begin
        if (acc && wr_en) r_rx[r_rx_cnt[AW-1:0]] <= it.rx_data;
    end

    kfip_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (acc),
        .i_res   (res),
        .i_cnt   (res_n),
        .o_empty (q_empty),
        .o_valid (q_valid),
        .o_res   (q_res),
        .i_ready (out_ch.ready)
    );

    assign out_ch.valid        = q_valid;
    assign out_ch.what         = q_res.what;
    assign out_ch.event_code   = q_res.event_code;
    assign out_ch.tx_byte      = q_res.tx_byte;
    assign out_ch.line_level   = q_res.line_level;
    assign out_ch.value_sensor = q_res.value_sensor;
    assign out_ch.sensor_value = q_res.sensor_value;
    assign out_ch.accepted     = q_res.accepted;
    assign out_ch.last         = q_res.last;

    a_sub_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub_cnt <= 3'(SENSOR_COUNT)) else $error("subscription count overflow");
    a_rx_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_cnt <= CW'(RX_DEPTH)) else $error("rx count overflow");
    a_stop_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !r_stop_pend) else $error("stop pending while idle");
endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-line fast-init poller: a driver and a result
// monitor around the block, a request-level predictor of the controller state
// updated on each accepted request, and register writes between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import kfip_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    kfip_in_if  in_ch();
    kfip_out_if out_ch();
    kfip_cfg_if cfg_ch();

    kline_fast_init_poller_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // controller prediction state
    // ------------------------------------------------------------------
    logic [9:0] r_wake_idle;
    logic [7:0] r_wake_low, r_wake_high, r_byte_gap, r_reply_to, r_poll_to;
    logic [3:0] r_one_shot;

    t_phase     ph = PH_IDLE;
    int         elapsed = 0;
    int         tx_idx = 0;
    logic [7:0] rx_mem [16] = '{default: 8'h00};
    int         rx_cnt = 0;
    bit         stop_pend = 1'b0;
    logic [1:0] subs [4] = '{default: 2'd0};
    int         sub_cnt = 0;
    int         sub_pos = 0;
    logic [1:0] cur_sensor = 2'd0;

    t_result expected_results[$];
    t_item   pending_requests[$];
    int      errors = 0;
    int      pushed_n;
    int      accepted_n = 0;
    int      results_n = 0;

    // message tables
    logic [7:0] start_msg [5] = '{8'hC1, 8'h33, 8'hF1, 8'h81, 8'h66};
    logic [7:0] stop_msg  [5] = '{8'hC1, 8'h33, 8'hF1, 8'h82, 8'h67};
    logic [7:0] poll_pid  [4] = '{8'h0C, 8'h05, 8'h0F, 8'h0D};
    logic [7:0] poll_sum  [4] = '{8'hF3, 8'hEC, 8'hF6, 8'hF4};
    int         reply_len [4] = '{14, 13, 13, 13};

    function automatic void add_result(logic [2:0] what, logic [3:0] code,
                                       logic [7:0] tx, logic [1:0] line,
                                       logic [1:0] vs, int val);
        t_result r;
        r = '0;
        r.what = what;
        r.event_code = code;
        r.tx_byte = tx;
        r.line_level = line;
        r.value_sensor = vs;
        r.sensor_value = val[14:0];
        expected_results.push_back(r);
    endfunction

    function automatic void add_event(logic [3:0] code);
        add_result(WHAT_EVENT, code, 8'h00, LINE_UART, 2'd0, 0);
    endfunction

    function automatic void store_rx(logic [7:0] b);
        if (rx_cnt < 16) begin
            rx_mem[rx_cnt] = b;
            rx_cnt++;
        end
    endfunction

    function automatic int decode_value(logic [1:0] s);
        if (s == 2'd0) return int'({rx_mem[11], rx_mem[12]}) >> 2;
        if (s == 2'd3) return int'(rx_mem[11]);
        return int'(rx_mem[11]) - 40;
    endfunction

    function automatic logic [7:0] poll_msg_byte(logic [1:0] s, int idx);
        case (idx)
            0: return 8'hC2;
            1: return 8'h33;
            2: return 8'hF1;
            3: return 8'h01;
            4: return poll_pid[s];
            default: return poll_sum[s];
        endcase
    endfunction

    // expected results of one accepted request
    function automatic void predict_request(t_item it);
        t_result d;
        bit      found;
        bit      acc;
        acc = 1'b0;
        if (it.kind) begin
            if (it.sensor >= 3'd4) begin
                add_event(EV_BAD_SENSOR);
            end else begin
                acc = 1'b1;
                found = 1'b0;
                for (int i = 0; i < sub_cnt; i++)
                    if (subs[i] == it.sensor[1:0]) found = 1'b1;
                if (!found && sub_cnt < 4) begin
                    subs[sub_cnt] = it.sensor[1:0];
                    sub_cnt++;
                end
            end
        end else begin
            if (elapsed < 65535) elapsed++;
            case (ph)
                PH_START, PH_WAKE_HIGH, PH_WAKE_LOW, PH_WAKE_END, PH_SEND_START: begin
                    if (it.init_req) add_event(EV_INIT_BUSY);
                    if (it.stop_req) begin
                        ph = PH_IDLE;
                        add_event(EV_STOP_OK);
                    end else if (ph == PH_START) begin
                        elapsed = 0;
                        add_result(WHAT_LINE, 4'd0, 8'h00, LINE_HIGH, 2'd0, 0);
                        ph = PH_WAKE_HIGH;
                    end else if (ph == PH_WAKE_HIGH) begin
                        if (elapsed >= r_wake_idle) begin
                            add_result(WHAT_LINE, 4'd0, 8'h00, LINE_LOW, 2'd0, 0);
                            elapsed = 0;
                            ph = PH_WAKE_LOW;
                        end
                    end else if (ph == PH_WAKE_LOW) begin
                        if (elapsed >= r_wake_low) begin
                            add_result(WHAT_LINE, 4'd0, 8'h00, LINE_HIGH, 2'd0, 0);
                            elapsed = 0;
                            ph = PH_WAKE_END;
                        end
                    end else if (ph == PH_WAKE_END) begin
                        if (elapsed >= r_wake_high) begin
                            add_result(WHAT_LINE, 4'd0, 8'h00, LINE_UART, 2'd0, 0);
                            rx_cnt = 0;
                            tx_idx = 0;
                            ph = PH_SEND_START;
                        end
                    end else begin
                        if (it.rx_valid) store_rx(it.rx_data);
                        if (elapsed >= r_byte_gap) begin
                            add_result(WHAT_TX, 4'd0, start_msg[tx_idx], LINE_UART, 2'd0, 0);
                            elapsed = 0;
                            tx_idx++;
                            if (tx_idx >= 5) begin
                                tx_idx = 0;
                                ph = PH_AWAIT_START;
                            end
                        end
                    end
                end
                PH_AWAIT_START: begin
                    if (it.init_req) add_event(EV_INIT_BUSY);
                    if (it.stop_req) stop_pend = 1'b1;
                    if (elapsed > r_reply_to) begin
                        ph = PH_IDLE;
                        add_event(EV_INIT_FAILED);
                        if (stop_pend) begin
                            stop_pend = 1'b0;
                            add_event(EV_STOP_OK);
                        end
                    end else if (it.rx_valid) begin
                        store_rx(it.rx_data);
                        if (rx_cnt >= 12) begin
                            elapsed = 0;
                            if (rx_mem[8] == START_ACK) begin
                                ph = PH_GAP;
                                if (!stop_pend) begin
                                    add_event(EV_INIT_OK);
                                    sub_pos = 0;
                                    cur_sensor = sub_cnt != 0 ? subs[0] : 2'd0;
                                end
                            end else begin
                                stop_pend = 1'b0;
                                ph = PH_IDLE;
                                add_event(EV_INIT_FAILED);
                            end
                        end
                    end
                end
                PH_GAP, PH_SEND_POLL, PH_AWAIT_POLL: begin
                    if (it.init_req) add_event(EV_ALREADY_INIT);
                    if (it.stop_req) stop_pend = 1'b1;
                    if (ph == PH_GAP) begin
                        if (elapsed > r_reply_to) begin
                            rx_cnt = 0;
                            tx_idx = 0;
                            ph = stop_pend ? PH_SEND_STOP : PH_SEND_POLL;
                        end
                    end else if (ph == PH_SEND_POLL) begin
                        if (it.rx_valid) store_rx(it.rx_data);
                        if (elapsed >= r_byte_gap) begin
                            add_result(WHAT_TX, 4'd0, poll_msg_byte(cur_sensor, tx_idx),
                                       LINE_UART, 2'd0, 0);
                            elapsed = 0;
                            tx_idx++;
                            if (tx_idx >= 6) begin
                                tx_idx = 0;
                                ph = PH_AWAIT_POLL;
                            end
                        end
                    end else begin
                        if (elapsed > r_poll_to) begin
                            tx_idx = 0;
                            rx_cnt = 0;
                            ph = stop_pend ? PH_SEND_STOP : PH_SEND_POLL;
                        end else if (it.rx_valid) begin
                            store_rx(it.rx_data);
                            elapsed = 0;
                            if (rx_cnt >= reply_len[cur_sensor]) begin
                                if (!stop_pend) begin
                                    if (sub_cnt != 0) begin
                                        add_result(WHAT_VALUE, 4'd0, 8'h00, LINE_UART,
                                                   cur_sensor, decode_value(cur_sensor));
                                        // one-shot: drop the entry, later ones slide down
                                        if (r_one_shot[cur_sensor]) begin
                                            for (int i = sub_pos + 1; i < sub_cnt; i++)
                                                subs[i - 1] = subs[i];
                                            sub_cnt--;
                                        end
                                    end
                                    if (sub_cnt != 0) begin
                                        sub_pos++;
                                        if (sub_pos >= sub_cnt) sub_pos = 0;
                                        cur_sensor = subs[sub_pos];
                                    end else begin
                                        cur_sensor = 2'd0;
                                    end
                                end
                                ph = PH_GAP;
                            end
                        end
                    end
                end
                PH_SEND_STOP, PH_AWAIT_STOP: begin
                    if (it.init_req) add_event(EV_INIT_STOPPING);
                    if (it.stop_req) add_event(EV_STOP_BUSY);
                    if (ph == PH_SEND_STOP) begin
                        if (it.rx_valid) store_rx(it.rx_data);
                        if (elapsed >= r_byte_gap) begin
                            add_result(WHAT_TX, 4'd0, stop_msg[tx_idx], LINE_UART, 2'd0, 0);
                            elapsed = 0;
                            tx_idx++;
                            if (tx_idx >= 5) begin
                                tx_idx = 0;
                                ph = PH_AWAIT_STOP;
                            end
                        end
                    end else begin
                        if (elapsed > r_reply_to) begin
                            stop_pend = 1'b0;
                            ph = PH_IDLE;
                            add_event(EV_STOP_FAILED);
                        end else if (it.rx_valid) begin
                            store_rx(it.rx_data);
                            if (rx_cnt >= 12) begin
                                elapsed = 0;
                                stop_pend = 1'b0;
                                ph = PH_IDLE;
                                add_event(rx_mem[8] == STOP_ACK ? EV_STOP_OK : EV_STOP_FAILED);
                            end
                        end
                    end
                end
                default: begin
                    ph = PH_IDLE;
                    if (it.stop_req) add_event(EV_ALREADY_STOPPED);
                    if (it.init_req) ph = PH_START;
                end
            endcase
        end
        d = '0;
        d.what = WHAT_DONE;
        d.accepted = acc;
        d.last = 1'b1;
        expected_results.push_back(d);
    endfunction

    // next request, mostly well-formed for the current controller phase
    function automatic t_item next_request();
        t_item it;
        int    r;
        it = '0;
        it.rx_data = 8'($urandom_range(0, 255));
        it.sensor = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 4 || (sub_cnt < 2 && r < 10)) begin
            it.kind = 1'b1;
            return it;
        end
        if (r < 18) begin
            it.init_req = 1'($urandom);
            it.stop_req = 1'($urandom);
            it.rx_valid = 1'($urandom);
            it.kind = ($urandom_range(0, 3) == 0);
            return it;
        end
        it.stop_req = ($urandom_range(0, 99) < 2);
        it.init_req = ($urandom_range(0, 99) < 3);
        case (ph)
            PH_IDLE: it.init_req = ($urandom_range(0, 9) != 0);
            PH_SEND_START, PH_SEND_POLL, PH_SEND_STOP:
                it.rx_valid = ($urandom_range(0, 2) == 0);
            PH_AWAIT_START: begin
                it.rx_valid = ($urandom_range(0, 3) != 0);
                if (rx_cnt == 8 && $urandom_range(0, 7) != 0) it.rx_data = START_ACK;
            end
            PH_AWAIT_POLL: it.rx_valid = ($urandom_range(0, 5) != 0);
            PH_AWAIT_STOP: begin
                it.rx_valid = ($urandom_range(0, 3) != 0);
                if (rx_cnt == 8 && $urandom_range(0, 7) != 0) it.rx_data = STOP_ACK;
            end
            default: ;
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    t_item cur_req;
    int    in_wait;
    bit    in_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.kind <= 1'b0;
            in_ch.init_req <= 1'b0;
            in_ch.stop_req <= 1'b0;
            in_ch.rx_valid <= 1'b0;
            in_ch.rx_data <= 8'h00;
            in_ch.sensor <= 3'd0;
            in_wait = 0;
            in_burst = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_request(cur_req);
                accepted_n++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_wait > 0) begin
                    in_wait--;
                    in_ch.valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_req = pending_requests.pop_front();
                    in_ch.kind <= cur_req.kind;
                    in_ch.init_req <= cur_req.init_req;
                    in_ch.stop_req <= cur_req.stop_req;
                    in_ch.rx_valid <= cur_req.rx_valid;
                    in_ch.rx_data <= cur_req.rx_data;
                    in_ch.sensor <= cur_req.sensor;
                    in_ch.valid <= 1'b1;
                    if ($urandom_range(0, 19) == 0) in_burst = ~in_burst;
                    in_wait = in_burst ? 0 : $urandom_range(0, 14);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    t_result got, want;
    int      out_wait;
    int      hold_left;
    bit      held;
    bit      out_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait = 0;
            hold_left = 0;
            held = 1'b0;
            out_burst = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.what = out_ch.what;
                got.event_code = out_ch.event_code;
                got.tx_byte = out_ch.tx_byte;
                got.line_level = out_ch.line_level;
                got.value_sensor = out_ch.value_sensor;
                got.sensor_value = out_ch.sensor_value;
                got.accepted = out_ch.accepted;
                got.last = out_ch.last;
                results_n++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.what != want.what || got.event_code != want.event_code ||
                        got.tx_byte != want.tx_byte || got.line_level != want.line_level ||
                        got.value_sensor != want.value_sensor ||
                        got.sensor_value != want.sensor_value ||
                        got.accepted != want.accepted || got.last != want.last) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
                if ($urandom_range(0, 19) == 0) out_burst = ~out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, 14);
                // one long hold-off so the result queue fills and input stalls
                if (!held && results_n == 60) begin
                    held = 1'b1;
                    hold_left = 300;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (out_wait > 0) begin
                out_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // run watchdog
    // ------------------------------------------------------------------
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(negedge i_clk);
        while (!cfg_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_WAKE_IDLE: r_wake_idle = val;
            REG_WAKE_LOW:  r_wake_low = val[7:0];
            REG_WAKE_HIGH: r_wake_high = val[7:0];
            REG_BYTE_GAP:  r_byte_gap = val[7:0];
            REG_REPLY_TO:  r_reply_to = val[7:0];
            REG_POLL_TO:   r_poll_to = val[7:0];
            REG_ONE_SHOT:  r_one_shot = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int idle, int low, int high, int gap, int reply,
                            int poll, int mask);
        write_reg(REG_WAKE_IDLE, 10'(idle));
        write_reg(REG_WAKE_LOW, 10'(low));
        write_reg(REG_WAKE_HIGH, 10'(high));
        write_reg(REG_BYTE_GAP, 10'(gap));
        write_reg(REG_REPLY_TO, 10'(reply));
        write_reg(REG_POLL_TO, 10'(poll));
        write_reg(REG_ONE_SHOT, 10'(mask));
    endtask

    // wait until every request is taken and every result is back
    task automatic drain();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || accepted_n != pushed_n ||
               expected_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++) begin
            @(negedge i_clk);
            while (accepted_n != pushed_n) @(negedge i_clk);
            pending_requests.push_back(next_request());
            pushed_n++;
        end
    endtask

    task automatic queue_req(bit kind, bit init, bit stop, bit rxv, logic [7:0] d,
                             logic [2:0] s);
        t_item it;
        it.kind = kind;
        it.init_req = init;
        it.stop_req = stop;
        it.rx_valid = rxv;
        it.rx_data = d;
        it.sensor = s;
        pending_requests.push_back(it);
        pushed_n++;
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = 3'd0;
        cfg_ch.data = 10'd0;
        pushed_n = 0;
        r_wake_idle = 10'd300;
        r_wake_low = 8'd25;
        r_wake_high = 8'd25;
        r_byte_gap = 8'd10;
        r_reply_to = 8'd100;
        r_poll_to = 8'd60;
        r_one_shot = 4'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short timings, no one-shot
        set_regs(2, 1, 0, 0, 20, 15, 0);

        // directed: bad sensors, all sensors, duplicate, idle stop, busy cases
        queue_req(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 3'd7);
        queue_req(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 3'd4);
        queue_req(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 3'd0);
        queue_req(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 3'd1);
        queue_req(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 3'd2);
        queue_req(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 3'd3);
        queue_req(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 3'd0);
        queue_req(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 3'd0);
        queue_req(1'b0, 1'b0, 1'b0, 1'b1, 8'hFF, 3'd0);
        queue_req(1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 3'd7);
        queue_req(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 3'd0);
        queue_req(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 3'd0);
        queue_req(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 3'd0);
        run_random(100);
        drain();

        // maximum register values, all one-shot
        set_regs(1023, 255, 255, 255, 255, 255, 15);
        run_random(30);
        drain();

        // zero timings
        set_regs(0, 0, 0, 0, 0, 0, 10);
        run_random(60);
        drain();

        // random short timings
        set_regs($urandom_range(0, 5), $urandom_range(0, 3), $urandom_range(0, 3),
                 $urandom_range(0, 2), $urandom_range(10, 40), $urandom_range(10, 30),
                 $urandom_range(0, 15));
        run_random(100);
        drain();

        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
